// ===== sv/nor_flash_command_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// NOR flash command sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NOR_FLASH_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition holds at every clock edge.
`define NFCS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("nfcs assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define NFCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfcs assertion failed");
// Consequent holds in the cycle after the antecedent.
`define NFCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfcs assertion failed");
`else
`define NFCS_ASSERT_ALWAYS(lbl, cond)
`define NFCS_ASSERT_IMPL(lbl, ante, cons)
`define NFCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/nfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcs_pkg
// Types, command codes and the bus cycle expansion table of the sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

    localparam int ADDR_W = 23;
    localparam int DATA_W = 16;
    localparam int STEP_W = 3;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [ADDR_W-1:0] UNLOCK_A1 = 23'h000555;
    localparam logic [ADDR_W-1:0] UNLOCK_A2 = 23'h0002AA;
    localparam logic [DATA_W-1:0] D_UNLOCK1 = 16'h00AA;
    localparam logic [DATA_W-1:0] D_UNLOCK2 = 16'h0055;
    localparam logic [DATA_W-1:0] D_PROGRAM = 16'h00A0;
    localparam logic [DATA_W-1:0] D_ERASE_SETUP = 16'h0080;
    localparam logic [DATA_W-1:0] D_SECTOR_ERASE = 16'h0030;
    localparam logic [DATA_W-1:0] D_READ_RESET = 16'h00F0;
    localparam int DQ7 = 7;
    localparam int DQ5 = 5;

    typedef enum logic [1:0] {
        MODE_PROGRAM = 2'd0,
        MODE_ERASE   = 2'd1,
        MODE_STATUS  = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_OK      = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_REJECT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_PROG     = 3'd0,
        CMD_ERASE    = 3'd1,
        CMD_END      = 3'd2,
        CMD_POLL     = 3'd3,
        CMD_PROG_OK  = 3'd4,
        CMD_ERASE_OK = 3'd5,
        CMD_ERASE_TO = 3'd6,
        CMD_REJECT   = 3'd7
    } cmd_t;

    typedef struct packed {
        mode_t              mode;
        logic [ADDR_W-1:0]  word_addr;
        logic [DATA_W-1:0]  data;
    } req_t;

    typedef struct packed {
        logic               bus_write;
        logic               bus_valid;
        logic [ADDR_W-1:0]  bus_addr;
        logic [DATA_W-1:0]  bus_data;
        status_t            status;
        logic               last;
    } res_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
    } q_entry_t;

    function automatic res_t bus_wr(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        res_t r;
        r.bus_write = 1'b1;
        r.bus_valid = 1'b1;
        r.bus_addr  = addr;
        r.bus_data  = data;
        r.status    = ST_BUSY;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic res_t bus_rd(logic [ADDR_W-1:0] addr);
        res_t r;
        r.bus_write = 1'b0;
        r.bus_valid = 1'b1;
        r.bus_addr  = addr;
        r.bus_data  = '0;
        r.status    = ST_BUSY;
        r.last      = 1'b0;
        return r;
    endfunction

    // One result of a command burst, selected by step; marks the final one.
    function automatic res_t expand(cmd_t cmd, logic [STEP_W-1:0] step,
                                    logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        res_t r;
        r = '0;
        case (cmd)
            CMD_PROG:
            begin
                case (step)
                    3'd0:    r = bus_wr(UNLOCK_A1, D_UNLOCK1);
                    3'd1:    r = bus_wr(UNLOCK_A2, D_UNLOCK2);
                    3'd2:    r = bus_wr(UNLOCK_A1, D_PROGRAM);
                    3'd3:    r = bus_wr(addr, data);
                    default:
                    begin
                        r = bus_rd(addr);
                        r.last = 1'b1;
                    end
                endcase
            end
            CMD_ERASE:
            begin
                case (step)
                    3'd0:    r = bus_wr(UNLOCK_A1, D_UNLOCK1);
                    3'd1:    r = bus_wr(UNLOCK_A2, D_UNLOCK2);
                    3'd2:    r = bus_wr(UNLOCK_A1, D_ERASE_SETUP);
                    3'd3:    r = bus_wr(UNLOCK_A1, D_UNLOCK1);
                    3'd4:    r = bus_wr(UNLOCK_A2, D_UNLOCK2);
                    3'd5:    r = bus_wr(addr, D_SECTOR_ERASE);
                    default:
                    begin
                        r = bus_rd(addr);
                        r.last = 1'b1;
                    end
                endcase
            end
            CMD_END:
            begin
                case (step)
                    3'd0:    r = bus_wr(UNLOCK_A1, D_UNLOCK1);
                    3'd1:    r = bus_wr(UNLOCK_A2, D_UNLOCK2);
                    default:
                    begin
                        r = bus_wr(UNLOCK_A1, D_READ_RESET);
                        r.status = ST_OK;
                        r.last = 1'b1;
                    end
                endcase
            end
            CMD_POLL:
            begin
                r = bus_rd(addr);
                r.last = 1'b1;
            end
            CMD_PROG_OK:
            begin
                r.status = ST_OK;
                r.last = 1'b1;
            end
            CMD_ERASE_OK:
            begin
                r = bus_wr(UNLOCK_A1, D_READ_RESET);
                r.status = ST_OK;
                r.last = 1'b1;
            end
            CMD_ERASE_TO:
            begin
                r = bus_wr('0, D_READ_RESET);
                r.status = ST_TIMEOUT;
                r.last = 1'b1;
            end
            default:
            begin
                r.status = ST_REJECT;
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/nfcs_front.sv =====
// ----------------------------------------------------------------------------
// nfcs_front
// Accepts requests, checks them against the phase and queues one command each.
// ----------------------------------------------------------------------------
`include "nor_flash_command_sequencer_core_macros.svh"

module nfcs_front #(
    parameter int ADDR_WORD_BITS = 23
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  nfcs_pkg::req_t     req,
    output logic               req_stall,
    output logic               push,
    output nfcs_pkg::q_entry_t push_entry,
    input  logic               full
);

    localparam int TA_W = (ADDR_WORD_BITS < nfcs_pkg::ADDR_W) ?
                          ADDR_WORD_BITS : nfcs_pkg::ADDR_W;
    localparam logic [nfcs_pkg::ADDR_W-1:0] ADDR_MASK =
        nfcs_pkg::ADDR_W'((64'd1 << TA_W) - 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PROG  = 3'b010,
        PH_ERASE = 3'b100
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [TA_W-1:0]            target_reg, target_next;
    logic                       exp_reg, exp_next;
    logic                       accept;
    logic                       idle;
    logic [nfcs_pkg::ADDR_W-1:0] addr_m;
    logic [nfcs_pkg::ADDR_W-1:0] target_w;

    assign accept    = req_valid && !full;
    assign req_stall = full;
    assign push      = accept;
    assign idle      = (phase_reg != PH_PROG) && (phase_reg != PH_ERASE);
    assign addr_m    = req.word_addr & ADDR_MASK;
    assign target_w  = nfcs_pkg::ADDR_W'(target_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        target_next      = target_reg;
        exp_next         = exp_reg;
        push_entry.cmd   = nfcs_pkg::CMD_REJECT;
        push_entry.addr  = '0;
        push_entry.data  = '0;
        case (req.mode)
            nfcs_pkg::MODE_PROGRAM:
            begin
                if (idle)
                begin
                    push_entry.cmd  = nfcs_pkg::CMD_PROG;
                    push_entry.addr = addr_m;
                    push_entry.data = req.data;
                    target_next     = addr_m[TA_W-1:0];
                    exp_next        = req.data[nfcs_pkg::DQ7];
                    phase_next      = PH_PROG;
                end
            end
            nfcs_pkg::MODE_ERASE:
            begin
                if (idle)
                begin
                    push_entry.cmd  = nfcs_pkg::CMD_ERASE;
                    push_entry.addr = addr_m;
                    target_next     = addr_m[TA_W-1:0];
                    phase_next      = PH_ERASE;
                end
            end
            nfcs_pkg::MODE_END:
            begin
                if (idle)
                begin
                    push_entry.cmd = nfcs_pkg::CMD_END;
                end
            end
            default:
            begin
                // status word returned while waiting
                if (phase_reg == PH_PROG)
                begin
                    if (req.data[nfcs_pkg::DQ7] == exp_reg)
                    begin
                        push_entry.cmd = nfcs_pkg::CMD_PROG_OK;
                        phase_next     = PH_IDLE;
                    end
                    else
                    begin
                        push_entry.cmd  = nfcs_pkg::CMD_POLL;
                        push_entry.addr = target_w;
                    end
                end
                else if (phase_reg == PH_ERASE)
                begin
                    if (req.data[nfcs_pkg::DQ7])
                    begin
                        push_entry.cmd = nfcs_pkg::CMD_ERASE_OK;
                        phase_next     = PH_IDLE;
                    end
                    else if (req.data[nfcs_pkg::DQ5])
                    begin
                        push_entry.cmd = nfcs_pkg::CMD_ERASE_TO;
                        phase_next     = PH_IDLE;
                    end
                    else
                    begin
                        push_entry.cmd  = nfcs_pkg::CMD_POLL;
                        push_entry.addr = target_w;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            target_reg <= '0;
            exp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            exp_reg    <= exp_next;
        end
    end

    `NFCS_ASSERT_NEXT(a_prog_enters_wait, accept && idle && req.mode == nfcs_pkg::MODE_PROGRAM, phase_reg == PH_PROG)
    `NFCS_ASSERT_NEXT(a_reject_keeps_phase, accept && push_entry.cmd == nfcs_pkg::CMD_REJECT, phase_reg == $past(phase_reg))

endmodule

// ===== sv/nfcs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// nfcs_cmd_fifo
// Short command queue between the request front and the bus cycle back end.
// ----------------------------------------------------------------------------
`include "nor_flash_command_sequencer_core_macros.svh"

module nfcs_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nfcs_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output nfcs_pkg::q_entry_t head
);

    nfcs_pkg::q_entry_t                mem_reg [nfcs_pkg::Q_DEPTH];
    logic [nfcs_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [nfcs_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [nfcs_pkg::Q_CNT_W-1:0]      count_reg;

    assign full       = (count_reg == nfcs_pkg::Q_CNT_W'(nfcs_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `NFCS_ASSERT_ALWAYS(a_count_in_range, count_reg <= nfcs_pkg::Q_CNT_W'(nfcs_pkg::Q_DEPTH))
    `NFCS_ASSERT_IMPL(a_no_pop_when_empty, pop, head_valid)

endmodule

// ===== sv/nfcs_back.sv =====
// ----------------------------------------------------------------------------
// nfcs_back
// Expands queued commands into bus cycles, one per clock unless stalled, into an output register.
// ----------------------------------------------------------------------------
`include "nor_flash_command_sequencer_core_macros.svh"

module nfcs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  nfcs_pkg::q_entry_t head,
    output logic               pop,
    output logic               res_valid,
    output nfcs_pkg::res_t     res,
    input  logic               res_stall
);

    logic [nfcs_pkg::STEP_W-1:0] step_reg;
    logic                        res_valid_reg;
    nfcs_pkg::res_t              res_reg;
    nfcs_pkg::res_t              cur;
    logic                        load;

    assign cur       = nfcs_pkg::expand(head.cmd, step_reg, head.addr, head.data);
    assign load      = head_valid && (!res_valid_reg || !res_stall);
    assign pop       = load && cur.last;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                res_valid_reg <= 1'b1;
                // advance within the burst, restart on its final cycle
                step_reg      <= cur.last ? '0 : step_reg + 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    `NFCS_ASSERT_IMPL(a_status_only_on_last, res_valid_reg && res_reg.status != nfcs_pkg::ST_BUSY, res_reg.last)
    `NFCS_ASSERT_IMPL(a_burst_keeps_head, step_reg != '0, head_valid)

endmodule

// ===== sv/nor_flash_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_core
// Host-side NOR flash program / erase sequencer with AMD-style unlock cycles.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): one request item per handshake,
//   mode program, erase, status word returned, or end (read reset).
//   res channel (res_valid / res_stall / res): the bus cycles each request
//   causes, one item per handshake, the final one flagged by last and
//   carrying the completion status.
//   A program request yields 5 items, an erase 7, an end 3; a returned status
//   word, or a request that does not fit the current phase, yields 1.
//   The first item of a request is written into the command queue at the
//   accepting edge, then loaded into the output register, where it is
//   presented until taken; a stalled output item holds it in the queue.
//   Throughput: one result item per clock while res_stall is low; the back
//   end walks each burst one step per clock unless the output item is held.
//   A two-entry command queue lets requests be taken while a burst drains.
//   Reset returns the phase to idle, clears the stored target and empties
//   the queue and output register.
//   When the receiver stalls, the output item holds; the queue fills and
//   then req_stall rises until the back end moves on.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_core #(
    parameter int ADDR_WORD_BITS = 23
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  nfcs_pkg::req_t req,
    output logic           req_stall,
    output logic           res_valid,
    output nfcs_pkg::res_t res,
    input  logic           res_stall
);

    // front to queue
    logic               push;
    nfcs_pkg::q_entry_t push_entry;
    logic               full;

    // queue to back end
    logic               pop;
    logic               head_valid;
    nfcs_pkg::q_entry_t head;

    // classify the request against the phase, update the phase on accept
    nfcs_front #(
        .ADDR_WORD_BITS (ADDR_WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .req_stall  (req_stall),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // hold commands while the back end drains a burst
    nfcs_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // expand each command into its bus cycles
    nfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_stall  (res_stall)
    );

endmodule

// ===== sim/nor_flash_command_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// NOR flash command sequencer testbench
// Drives program, erase, status and end requests through the request channel
// and checks every bus cycle item on the result channel against a cycle-free
// model of the unlock sequences and the status polling, with random idling on
// both sides.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_WORD_BITS = 23;
    localparam logic [nfcs_pkg::ADDR_W-1:0] ADDR_MASK =
        nfcs_pkg::ADDR_W'((64'd1 << ADDR_WORD_BITS) - 64'd1);
    localparam int RANDOM_TOTAL = 260;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    // Phase of the flash operation as the host sees it.
    typedef enum logic [1:0] {
        FL_IDLE         = 2'd0,
        FL_PROGRAM_WAIT = 2'd1,
        FL_ERASE_WAIT   = 2'd2,
        FL_SPARE        = 2'd3
    } flash_phase_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    nfcs_pkg::req_t   req = '0;
    logic             req_stall;
    logic             res_valid;
    nfcs_pkg::res_t   res;
    logic             res_stall = 1'b0;

    // Requests waiting to be driven, and bus cycle items still owed by the block.
    nfcs_pkg::req_t   pending_reqs[$];
    nfcs_pkg::res_t   owed_bus_items[$];

    // Sequencer state as tracked at request acceptance.
    flash_phase_t                    op_phase = FL_IDLE;
    logic [nfcs_pkg::ADDR_W-1:0]     op_target = '0;
    logic                            op_dq7 = 1'b0;

    // Phase shadow used only while building the request list, so that
    // well-formed sequences can be closed before a new one starts.
    flash_phase_t          plan_phase = FL_IDLE;
    logic                  plan_dq7 = 1'b0;
    int                    planned_reqs = 0;

    int     taken_reqs = 0;
    int     seen_items = 0;
    int     req_gap = 0;
    int     stall_left = 0;
    int     mismatches = 0;
    int     cycle_count = 0;

    nor_flash_command_sequencer_core #(
        .ADDR_WORD_BITS (ADDR_WORD_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

    always #2 clk = ~clk;

    // Draw an idle count; every fourth stretch of 32 items runs with no idling.
    function automatic int draw_wait(int count);
        if (((count / 32) % 4) == 3)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [nfcs_pkg::ADDR_W-1:0] rand_addr();
        return nfcs_pkg::ADDR_W'($urandom());
    endfunction

    function automatic logic [nfcs_pkg::DATA_W-1:0] rand_data();
        return nfcs_pkg::DATA_W'($urandom());
    endfunction

    task automatic owe_cycle(logic wr, logic vld, logic [nfcs_pkg::ADDR_W-1:0] addr,
                             logic [nfcs_pkg::DATA_W-1:0] data,
                             nfcs_pkg::status_t st, logic fin);
        nfcs_pkg::res_t item;
        item.bus_write = wr;
        item.bus_valid = vld;
        item.bus_addr  = addr & ADDR_MASK;
        item.bus_data  = data;
        item.status    = st;
        item.last      = fin;
        owed_bus_items.push_back(item);
    endtask

    // Work out the bus cycles one accepted request causes and advance the phase.
    task automatic sequence_request(nfcs_pkg::req_t rq);
        logic [nfcs_pkg::ADDR_W-1:0] addr;
        logic                        idle;
        addr = rq.word_addr & ADDR_MASK;
        idle = (op_phase != FL_PROGRAM_WAIT) && (op_phase != FL_ERASE_WAIT);
        if (rq.mode == nfcs_pkg::MODE_PROGRAM && idle)
        begin
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_UNLOCK1,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A2, nfcs_pkg::D_UNLOCK2,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_PROGRAM,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, addr, rq.data, nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b0, 1'b1, addr, '0, nfcs_pkg::ST_BUSY, 1'b1);
            op_target = addr;
            op_dq7 = rq.data[nfcs_pkg::DQ7];
            op_phase = FL_PROGRAM_WAIT;
        end
        else if (rq.mode == nfcs_pkg::MODE_ERASE && idle)
        begin
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_UNLOCK1,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A2, nfcs_pkg::D_UNLOCK2,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_ERASE_SETUP,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_UNLOCK1,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A2, nfcs_pkg::D_UNLOCK2,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, addr, nfcs_pkg::D_SECTOR_ERASE, nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b0, 1'b1, addr, '0, nfcs_pkg::ST_BUSY, 1'b1);
            op_target = addr;
            op_phase = FL_ERASE_WAIT;
        end
        else if (rq.mode == nfcs_pkg::MODE_END && idle)
        begin
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_UNLOCK1,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A2, nfcs_pkg::D_UNLOCK2,
                      nfcs_pkg::ST_BUSY, 1'b0);
            owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_READ_RESET,
                      nfcs_pkg::ST_OK, 1'b1);
        end
        else if (rq.mode == nfcs_pkg::MODE_STATUS && op_phase == FL_PROGRAM_WAIT)
        begin
            if (rq.data[nfcs_pkg::DQ7] == op_dq7)
            begin
                owe_cycle(1'b0, 1'b0, '0, '0, nfcs_pkg::ST_OK, 1'b1);
                op_phase = FL_IDLE;
            end
            else
                owe_cycle(1'b0, 1'b1, op_target, '0, nfcs_pkg::ST_BUSY, 1'b1);
        end
        else if (rq.mode == nfcs_pkg::MODE_STATUS && op_phase == FL_ERASE_WAIT)
        begin
            if (rq.data[nfcs_pkg::DQ7])
            begin
                owe_cycle(1'b1, 1'b1, nfcs_pkg::UNLOCK_A1, nfcs_pkg::D_READ_RESET,
                          nfcs_pkg::ST_OK, 1'b1);
                op_phase = FL_IDLE;
            end
            else if (rq.data[nfcs_pkg::DQ5])
            begin
                owe_cycle(1'b1, 1'b1, '0, nfcs_pkg::D_READ_RESET,
                          nfcs_pkg::ST_TIMEOUT, 1'b1);
                op_phase = FL_IDLE;
            end
            else
                owe_cycle(1'b0, 1'b1, op_target, '0, nfcs_pkg::ST_BUSY, 1'b1);
        end
        else
            owe_cycle(1'b0, 1'b0, '0, '0, nfcs_pkg::ST_REJECT, 1'b1);
    endtask

    // Queue one request and track which phase it leaves the flash in.
    task automatic enqueue(nfcs_pkg::mode_t m, logic [nfcs_pkg::ADDR_W-1:0] addr,
                           logic [nfcs_pkg::DATA_W-1:0] data);
        nfcs_pkg::req_t rq;
        logic           idle;
        rq.mode = m;
        rq.word_addr = addr;
        rq.data = data;
        pending_reqs.push_back(rq);
        planned_reqs++;
        idle = (plan_phase != FL_PROGRAM_WAIT) && (plan_phase != FL_ERASE_WAIT);
        if (idle && m == nfcs_pkg::MODE_PROGRAM)
        begin
            plan_phase = FL_PROGRAM_WAIT;
            plan_dq7 = data[nfcs_pkg::DQ7];
        end
        else if (idle && m == nfcs_pkg::MODE_ERASE)
            plan_phase = FL_ERASE_WAIT;
        else if (m == nfcs_pkg::MODE_STATUS && plan_phase == FL_PROGRAM_WAIT
                 && data[nfcs_pkg::DQ7] == plan_dq7)
            plan_phase = FL_IDLE;
        else if (m == nfcs_pkg::MODE_STATUS && plan_phase == FL_ERASE_WAIT
                 && (data[nfcs_pkg::DQ7] || data[nfcs_pkg::DQ5]))
            plan_phase = FL_IDLE;
    endtask

    // Close any operation left open, with a status word that ends it.
    task automatic settle();
        logic [nfcs_pkg::DATA_W-1:0] s;
        s = rand_data();
        if (plan_phase == FL_PROGRAM_WAIT)
        begin
            s[nfcs_pkg::DQ7] = plan_dq7;
            enqueue(nfcs_pkg::MODE_STATUS, rand_addr(), s);
        end
        else if (plan_phase == FL_ERASE_WAIT)
        begin
            s[nfcs_pkg::DQ7] = 1'b1;
            enqueue(nfcs_pkg::MODE_STATUS, rand_addr(), s);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Request driver: hold the item while stalled, insert the drawn gap after
    // each accepted item, then load the next pending one.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        logic took;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap <= 0;
        end
        else
        begin
            took = req_valid && !req_stall;
            if (took)
            begin
                sequence_request(req);
                taken_reqs++;
            end
            if (took || !req_valid)
            begin
                if (req_gap > 0)
                begin
                    req_valid <= 1'b0;
                    req_gap <= req_gap - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_gap <= draw_wait(taken_reqs);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted item with the oldest owed one,
    // then stall for the drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        nfcs_pkg::res_t want;
        int             hold;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (res_valid && !res_stall)
        begin
            if (owed_bus_items.size() == 0)
            begin
                $error("unexpected bus item: %h", res);
                mismatches++;
            end
            else
            begin
                want = owed_bus_items.pop_front();
                check_field("bus_write", 32'(want.bus_write), 32'(res.bus_write));
                check_field("bus_valid", 32'(want.bus_valid), 32'(res.bus_valid));
                check_field("bus_addr", 32'(want.bus_addr), 32'(res.bus_addr));
                check_field("bus_data", 32'(want.bus_data), 32'(res.bus_data));
                check_field("status", 32'(want.status), 32'(res.status));
                check_field("last", 32'(want.last), 32'(res.last));
            end
            seen_items++;
            hold = draw_wait(seen_items);
            stall_left <= hold;
            res_stall <= (hold != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_stall <= (stall_left > 1);
        end
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                          pick;
        int                          polls;
        nfcs_pkg::mode_t             stray;
        logic [nfcs_pkg::ADDR_W-1:0] a;
        logic [nfcs_pkg::DATA_W-1:0] d;
        logic [nfcs_pkg::DATA_W-1:0] s;

        // Directed: rejects in idle and while waiting, program done on either
        // DQ7 value, busy polls, erase done, erase timeout, DQ7 winning over
        // DQ5, read reset, and the address and data extremes.
        enqueue(nfcs_pkg::MODE_STATUS, 23'h7FFFFF, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_END, 23'h7FFFFF, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_PROGRAM, 23'h000000, 16'h0000);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h000000, 16'h0080);
        enqueue(nfcs_pkg::MODE_PROGRAM, 23'h7FFFFF, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_ERASE, 23'h7FFFFF, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_END, 23'h000000, 16'h0000);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h7FFFFF, 16'hFF7F);
        enqueue(nfcs_pkg::MODE_PROGRAM, 23'h7FFFFF, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h000000, 16'h0000);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h000000, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_ERASE, 23'h7FFFFF, 16'h0000);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h000000, 16'h0000);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h7FFFFF, 16'hFF5F);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h000000, 16'h0020);
        enqueue(nfcs_pkg::MODE_ERASE, 23'h2AAAAA, 16'h5555);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h555555, 16'h00A0);
        enqueue(nfcs_pkg::MODE_ERASE, 23'h000000, 16'hFFFF);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h2AAAAA, 16'h0080);
        enqueue(nfcs_pkg::MODE_PROGRAM, 23'h555555, 16'h5A80);
        enqueue(nfcs_pkg::MODE_STATUS, 23'h555555, 16'h0080);
        enqueue(nfcs_pkg::MODE_END, 23'h2AAAAA, 16'hAAAA);

        // Random: mostly complete program and erase sequences with random
        // content and a few stray requests, the rest plain noise.
        while (planned_reqs < RANDOM_TOTAL)
        begin
            pick = $urandom_range(0, 9);
            a = rand_addr();
            d = rand_data();
            if (pick <= 3)
            begin
                settle();
                enqueue(nfcs_pkg::MODE_PROGRAM, a, d);
                polls = $urandom_range(0, 3);
                repeat (polls)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        stray = nfcs_pkg::mode_t'($urandom_range(0, 2));
                        if (stray == nfcs_pkg::MODE_STATUS)
                            stray = nfcs_pkg::MODE_END;
                        enqueue(stray, rand_addr(), rand_data());
                    end
                    s = rand_data();
                    s[nfcs_pkg::DQ7] = ~d[nfcs_pkg::DQ7];
                    enqueue(nfcs_pkg::MODE_STATUS, rand_addr(), s);
                end
                s = rand_data();
                s[nfcs_pkg::DQ7] = d[nfcs_pkg::DQ7];
                enqueue(nfcs_pkg::MODE_STATUS, rand_addr(), s);
            end
            else if (pick <= 6)
            begin
                settle();
                enqueue(nfcs_pkg::MODE_ERASE, a, d);
                polls = $urandom_range(0, 3);
                repeat (polls)
                begin
                    s = rand_data();
                    s[nfcs_pkg::DQ7] = 1'b0;
                    s[nfcs_pkg::DQ5] = 1'b0;
                    enqueue(nfcs_pkg::MODE_STATUS, rand_addr(), s);
                end
                s = rand_data();
                if ($urandom_range(0, 1) == 0)
                    s[nfcs_pkg::DQ7] = 1'b1;
                else
                begin
                    s[nfcs_pkg::DQ7] = 1'b0;
                    s[nfcs_pkg::DQ5] = 1'b1;
                end
                enqueue(nfcs_pkg::MODE_STATUS, rand_addr(), s);
            end
            else if (pick == 7)
            begin
                settle();
                enqueue(nfcs_pkg::MODE_END, a, d);
            end
            else
                enqueue(nfcs_pkg::mode_t'($urandom_range(0, 3)), a, d);
        end

        // Hold reset, then release it once.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken, every owed item to arrive,
        // then let the pipeline drain to catch stray items.
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (owed_bus_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
